// ===== hw/rtl/packed_yuv422_to_rgb_unit_defines.svh =====
// assertion macros shared by the checking code of the converter
`ifndef PACKED_YUV422_TO_RGB_UNIT_DEFINES_SVH
`define PACKED_YUV422_TO_RGB_UNIT_DEFINES_SVH

// condition must hold in the same cycle as its trigger
`define PY2R_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// condition must hold in the cycle after its trigger
`define PY2R_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/py2r_pkg.sv =====
package py2r_pkg;

	// sizes
	localparam int QUEUE_DEPTH = 4;
	localparam int CHAN_W      = 8;
	localparam int TERM_W      = 19;
	localparam int FRAC_BITS   = 10;
	localparam int SUM_W       = 21;

	// packed byte orders
	typedef enum logic [1:0] {
		ORDER_YUYV = 2'd0,
		ORDER_UYVY = 2'd1,
		ORDER_YVYU = 2'd2,
		ORDER_VYUY = 2'd3
	} byte_order_t;

	// chroma coefficients in q.10
	localparam logic signed [TERM_W-1:0] COEF_RV = 19'sd1441;
	localparam logic signed [TERM_W-1:0] COEF_GU = 19'sd354;
	localparam logic signed [TERM_W-1:0] COEF_GV = 19'sd734;
	localparam logic signed [TERM_W-1:0] COEF_BU = 19'sd1822;

	// one classified group: both luma samples and the chroma terms of each channel
	typedef struct packed {
		logic [CHAN_W-1:0]        y1;
		logic [CHAN_W-1:0]        y2;
		logic signed [TERM_W-1:0] term_r;
		logic signed [TERM_W-1:0] term_g;
		logic signed [TERM_W-1:0] term_b;
		logic                     last;
	} group_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// one output pixel
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              pair_last;
		logic              end_of_frame;
	} pixel_t;

endpackage

// ===== hw/rtl/py2r_front.sv =====
module py2r_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  py2r_pkg::byte_order_t byte_order,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            byte0,
	input  logic [7:0]            byte1,
	input  logic [7:0]            byte2,
	input  logic [7:0]            byte3,
	input  logic                  last_group,
	input  py2r_pkg::qstat_t      q_stat,
	output logic                  q_push,
	output py2r_pkg::group_t      q_data
);

	logic [7:0]                         y1, y2, u, v;
	logic signed [7:0]                  du, dv;
	logic signed [py2r_pkg::TERM_W-1:0] du_w, dv_w;
	logic                               accept;
	logic                               valid_s1;
	py2r_pkg::group_t                   group_s1;
	py2r_pkg::group_t                   group_d;

	// unpack the group by byte order
	always_comb begin
		unique case (byte_order)
			py2r_pkg::ORDER_YUYV: begin
				y1 = byte0; u = byte1; y2 = byte2; v = byte3;
			end
			py2r_pkg::ORDER_UYVY: begin
				u = byte0; y1 = byte1; v = byte2; y2 = byte3;
			end
			py2r_pkg::ORDER_YVYU: begin
				y1 = byte0; v = byte1; y2 = byte2; u = byte3;
			end
			py2r_pkg::ORDER_VYUY: begin
				v = byte0; y1 = byte1; u = byte2; y2 = byte3;
			end
			default: begin
				y1 = byte0; u = byte1; y2 = byte2; v = byte3;
			end
		endcase
	end

	// chroma minus mid level is the sample with its top bit flipped
	assign du   = {~u[7], u[6:0]};
	assign dv   = {~v[7], v[6:0]};
	assign du_w = py2r_pkg::TERM_W'(du);
	assign dv_w = py2r_pkg::TERM_W'(dv);

	// chroma terms, green already negated
	always_comb begin
		group_d.y1     = y1;
		group_d.y2     = y2;
		group_d.term_r = dv_w * py2r_pkg::COEF_RV;
		group_d.term_g = -(du_w * py2r_pkg::COEF_GU) - (dv_w * py2r_pkg::COEF_GV);
		group_d.term_b = du_w * py2r_pkg::COEF_BU;
		group_d.last   = last_group;
	end

	// stage handshake: hold while the queue is full
	assign full   = valid_s1 & q_stat.full;
	assign accept = push & ~full;
	assign q_push = valid_s1 & ~q_stat.full;
	assign q_data = group_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			group_s1 <= group_d;
		end
	end

endmodule

// ===== hw/rtl/py2r_queue.sv =====
module py2r_queue #(
	parameter int DEPTH = py2r_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  py2r_pkg::group_t data_in,
	input  logic             pop,
	output py2r_pkg::group_t data_out,
	output py2r_pkg::qstat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	py2r_pkg::group_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & ~stat.empty;
	assign data_out   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

endmodule

// ===== hw/rtl/py2r_back.sv =====
module py2r_back (
	input  logic             clk,
	input  logic             arst_n,
	input  py2r_pkg::group_t head,
	input  py2r_pkg::qstat_t q_stat,
	output logic             q_pop,
	output logic             phase,
	input  logic             pop,
	output logic             empty,
	output py2r_pkg::pixel_t pixel
);

	py2r_pkg::pixel_t obuf_q [2];
	logic             obuf_wr_q, obuf_rd_q;
	logic [1:0]       ocount_q;
	logic             phase_q;
	logic             emit, take;
	logic [7:0]       y;
	py2r_pkg::pixel_t pix_d;

	// floor of the q.10 sum, clamped to a byte
	function automatic logic [7:0] to_channel(
		input logic [7:0]                         luma,
		input logic signed [py2r_pkg::TERM_W-1:0] term
	);
		logic signed [py2r_pkg::SUM_W-1:0] sum;
		logic signed [10:0]                whole;
		sum   = $signed({3'b000, luma, 10'b0}) + py2r_pkg::SUM_W'(term);
		whole = sum[py2r_pkg::SUM_W-1:py2r_pkg::FRAC_BITS];
		if (whole[10]) begin
			return 8'd0;
		end else if (|whole[9:8]) begin
			return 8'd255;
		end else begin
			return whole[7:0];
		end
	endfunction

	// one pixel per cycle while the queue holds a group and the output buffer has room
	assign emit  = ~q_stat.empty & (ocount_q != 2'd2);
	assign q_pop = emit & phase_q;
	assign phase = phase_q;
	assign y     = phase_q ? head.y2 : head.y1;

	always_comb begin
		pix_d.red          = to_channel(y, head.term_r);
		pix_d.green        = to_channel(y, head.term_g);
		pix_d.blue         = to_channel(y, head.term_b);
		pix_d.pair_last    = phase_q;
		pix_d.end_of_frame = phase_q & head.last;
	end

	// output buffer towards the consumer
	assign empty = (ocount_q == 2'd0);
	assign take  = pop & ~empty;
	assign pixel = obuf_q[obuf_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 1'b0;
			obuf_wr_q <= 1'b0;
			obuf_rd_q <= 1'b0;
			ocount_q  <= 2'd0;
		end else begin
			if (emit) begin
				phase_q   <= ~phase_q;
				obuf_wr_q <= ~obuf_wr_q;
			end
			if (take) begin
				obuf_rd_q <= ~obuf_rd_q;
			end
			if (emit && !take) begin
				ocount_q <= ocount_q + 2'd1;
			end else if (take && !emit) begin
				ocount_q <= ocount_q - 2'd1;
			end
		end
	end

	// buffer payload
	always_ff @(posedge clk) begin
		if (emit) begin
			obuf_q[obuf_wr_q] <= pix_d;
		end
	end

endmodule

// ===== hw/rtl/packed_yuv422_to_rgb_unit.sv =====
// path: front stage register, group queue, output buffer; the first pixel of a group is
// written to the output buffer before the second
// throughput: one pixel per cycle while a group is queued and the output buffer has room
// reset (arst_n low, asynchronous): queues empty, byte order YUYV, results empty
module packed_yuv422_to_rgb_unit #(
	parameter int QUEUE_DEPTH = py2r_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] byte0,
	input  logic [7:0] byte1,
	input  logic [7:0] byte2,
	input  logic [7:0] byte3,
	input  logic       last_group,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       pair_last,
	output logic       end_of_frame
);

`include "packed_yuv422_to_rgb_unit_defines.svh"

	py2r_pkg::byte_order_t byte_order_q;
	py2r_pkg::qstat_t      q_stat;
	py2r_pkg::group_t      q_in, q_head;
	py2r_pkg::pixel_t      pixel;
	logic                  q_push, q_pop, phase;

	// byte order register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= py2r_pkg::ORDER_YUYV;
		end else if (cfg_valid) begin
			byte_order_q <= py2r_pkg::byte_order_t'(cfg_data);
		end
	end

	// front: unpack and chroma terms
	py2r_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_order (byte_order_q),
		.push       (push),
		.full       (full),
		.byte0      (byte0),
		.byte1      (byte1),
		.byte2      (byte2),
		.byte3      (byte3),
		.last_group (last_group),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	// group queue between the two halves
	py2r_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.data_in  (q_in),
		.pop      (q_pop),
		.data_out (q_head),
		.stat     (q_stat)
	);

	// back: two pixels per group
	py2r_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.phase  (phase),
		.pop    (pop),
		.empty  (empty),
		.pixel  (pixel)
	);

	assign red          = pixel.red;
	assign green        = pixel.green;
	assign blue         = pixel.blue;
	assign pair_last    = pixel.pair_last;
	assign end_of_frame = pixel.end_of_frame;

	// checks
	`PY2R_ASSERT_NOW(a_phase_has_head, phase, !q_stat.empty, "second pixel without a queued group")
	`PY2R_ASSERT_NEXT(a_accept_moves, push && !full, full || q_push, "taken item neither held nor queued")
	`PY2R_ASSERT_NEXT(a_queue_fills, q_push && q_stat.empty, !q_stat.empty, "queued item lost")

endmodule

// ===== test/packed_yuv422_to_rgb_unit_tb.sv =====
module packed_yuv422_to_rgb_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// pipeline latency, used as extra margin when waiting for the block to drain
	localparam int PIPE_LATENCY = 2;
	localparam int GROUPS_PER_PHASE = 50;

	// q.10 chroma weights
	localparam int RV_Q10 = 1441;
	localparam int GU_Q10 = 354;
	localparam int GV_Q10 = 734;
	localparam int BU_Q10 = 1822;
	localparam int CHROMA_ZERO = 128;

	// receiver stall styles
	typedef enum logic [1:0] {
		RX_STREAM,
		RX_RANDOM,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_data = 2'd0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] byte0 = 8'd0;
	logic [7:0] byte1 = 8'd0;
	logic [7:0] byte2 = 8'd0;
	logic [7:0] byte3 = 8'd0;
	logic       last_group = 1'b0;
	logic       pop = 1'b0;
	logic       empty;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       pair_last;
	logic       end_of_frame;

	py2r_pkg::pixel_t      expected_pixels[$];
	py2r_pkg::byte_order_t active_order = py2r_pkg::ORDER_YUYV;
	int                    fail_count = 0;
	bit                    pacing_on = 1'b1;
	int                    burst_left = 0;

	packed_yuv422_to_rgb_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.byte0(byte0),
		.byte1(byte1),
		.byte2(byte2),
		.byte3(byte3),
		.last_group(last_group),
		.pop(pop),
		.empty(empty),
		.red(red),
		.green(green),
		.blue(blue),
		.pair_last(pair_last),
		.end_of_frame(end_of_frame)
	);

	always #5 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(string what, int got, int want);
		fail_count++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	// floor of q.10 sum, clamped to a byte
	function automatic logic [7:0] clamp_channel(int acc);
		int whole;
		whole = acc >>> 10;
		if (whole < 0) begin
			return 8'd0;
		end
		if (whole > 255) begin
			return 8'd255;
		end
		return whole[7:0];
	endfunction

	function automatic py2r_pkg::pixel_t rgb_from_yuv(int luma, int du, int dv, bit second,
			bit eof);
		py2r_pkg::pixel_t px;
		px.red          = clamp_channel(luma * 1024 + RV_Q10 * dv);
		px.green        = clamp_channel(luma * 1024 - GU_Q10 * du - GV_Q10 * dv);
		px.blue         = clamp_channel(luma * 1024 + BU_Q10 * du);
		px.pair_last    = second;
		px.end_of_frame = eof;
		return px;
	endfunction

	// unpack the group by the current order and queue both pixels
	task automatic queue_group_pixels(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
			logic [7:0] b3, logic last);
		int y1;
		int y2;
		int u;
		int v;
		case (active_order)
			py2r_pkg::ORDER_YUYV: begin
				y1 = int'(b0); u = int'(b1); y2 = int'(b2); v = int'(b3);
			end
			py2r_pkg::ORDER_UYVY: begin
				u = int'(b0); y1 = int'(b1); v = int'(b2); y2 = int'(b3);
			end
			py2r_pkg::ORDER_YVYU: begin
				y1 = int'(b0); v = int'(b1); y2 = int'(b2); u = int'(b3);
			end
			default: begin
				v = int'(b0); y1 = int'(b1); u = int'(b2); y2 = int'(b3);
			end
		endcase
		expected_pixels.push_back(rgb_from_yuv(y1, u - CHROMA_ZERO, v - CHROMA_ZERO, 1'b0, 1'b0));
		expected_pixels.push_back(rgb_from_yuv(y2, u - CHROMA_ZERO, v - CHROMA_ZERO, 1'b1, last));
	endtask

	// offer one group, with random gaps between bursts when pacing is on
	task automatic send_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
			logic [7:0] b3, logic last);
		if (pacing_on && burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		push       <= 1'b1;
		byte0      <= b0;
		byte1      <= b1;
		byte2      <= b2;
		byte3      <= b3;
		last_group <= last;
		do @(posedge clk); while (full);
		queue_group_pixels(b0, b1, b2, b3, last);
	endtask

	// hold off until every queued pixel has been read back
	task automatic wait_for_drain();
		push <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_byte_order(py2r_pkg::byte_order_t order);
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_data  <= order;
		do @(posedge clk); while (!cfg_ready);
		active_order = order;
		cfg_valid <= 1'b0;
	endtask

	// byte mix that favours the clamp limits and the chroma midpoint
	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 4))
			0, 1: return 8'($urandom_range(0, 255));
			2: return $urandom_range(0, 1) ? 8'hff : 8'h00;
			3: return $urandom_range(0, 1) ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 15));
			default: return 8'($urandom_range(120, 136));
		endcase
	endfunction

	// groups sent before any register write use the reset order
	task automatic test_reset_order();
		send_group(8'h10, 8'h80, 8'heb, 8'h80, 1'b0);
		send_group(8'h51, 8'h5a, 8'ha2, 8'hf0, 1'b0);
		send_group(8'h00, 8'hff, 8'hff, 8'h00, 1'b1);
		send_group(8'hff, 8'h00, 8'h00, 8'hff, 1'b0);
	endtask

	// extreme groups under every byte order, both clamp limits reached
	task automatic test_order_extremes();
		for (int k = 0; k < 4; k++) begin
			write_byte_order(py2r_pkg::byte_order_t'(k));
			send_group(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
			send_group(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
			send_group(8'h00, 8'hff, 8'h00, 8'hff, 1'b0);
			send_group(8'hff, 8'h00, 8'hff, 8'h00, 1'b0);
			send_group(8'h80, 8'h80, 8'h80, 8'h80, 1'b1);
		end
	endtask

	// random groups over several order settings, one phase without gaps
	task automatic test_random_groups();
		py2r_pkg::byte_order_t order;
		for (int phase = 0; phase < 8; phase++) begin
			if (phase < 4) begin
				order = py2r_pkg::byte_order_t'(3 - phase);
			end else begin
				order = py2r_pkg::byte_order_t'($urandom_range(0, 3));
			end
			write_byte_order(order);
			pacing_on = (phase != 6);
			burst_left = 0;
			for (int n = 0; n < GROUPS_PER_PHASE; n++) begin
				// let the output side empty out completely mid stream
				if (phase == 4 && n == GROUPS_PER_PHASE / 2) begin
					wait_for_drain();
				end
				send_group(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
					$urandom_range(0, 7) == 0);
			end
		end
		pacing_on = 1'b1;
	endtask

	// receiver stall pattern, with a random style that is redrawn when its phase runs out
	rx_mode_t rx_mode = RX_STREAM;
	int       rx_phase_left = 0;
	int       rx_cycle = 0;

	always @(posedge clk) begin
		rx_cycle++;
		if (rx_phase_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_phase_left = $urandom_range(30, 150);
		end else begin
			rx_phase_left--;
		end
		case (rx_mode)
			RX_STREAM: pop <= 1'b1;
			RX_RANDOM: pop <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: pop <= rx_cycle[2];
			default: pop <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// compare each pixel read out against the oldest prediction
	always @(posedge clk) begin
		py2r_pkg::pixel_t want;
		if (arst_n && pop && !empty) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("pixel with none pending, red", int'(red), -1);
			end else begin
				want = expected_pixels.pop_front();
				if (red !== want.red) begin
					report_mismatch("red", int'(red), int'(want.red));
				end
				if (green !== want.green) begin
					report_mismatch("green", int'(green), int'(want.green));
				end
				if (blue !== want.blue) begin
					report_mismatch("blue", int'(blue), int'(want.blue));
				end
				if (pair_last !== want.pair_last) begin
					report_mismatch("pair_last", int'(pair_last), int'(want.pair_last));
				end
				if (end_of_frame !== want.end_of_frame) begin
					report_mismatch("end_of_frame", int'(end_of_frame),
						int'(want.end_of_frame));
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_order();
		test_order_extremes();
		test_random_groups();
		wait_for_drain();
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
